FILE: rtl/rkh_pkg.sv
// Package for the record key hash block: shared constants, types and byte
// classification helpers. No dependencies.
package rkh_pkg;

   localparam int HASH_WIDTH_DEF = 64;
   localparam int QUEUE_DEPTH    = 2;
   localparam logic [31:0] BUCKET_RESET = 32'd1024;
   localparam logic [31:0] HOUSE_BIAS   = 32'd17;

   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_VT      = 8'h0B;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_COMMA   = 8'h2C;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_UP_A    = 8'h41;
   localparam logic [7:0] CH_UP_Z    = 8'h5A;
   localparam logic [7:0] CH_LO_A    = 8'h61;
   localparam logic [7:0] CH_LO_Z    = 8'h7A;
   localparam logic [7:0] CASE_BIT   = 8'h20;

   localparam logic [1:0] LINE_SURNAME  = 2'd0;
   localparam logic [1:0] LINE_ADDRESS  = 2'd1;
   localparam logic [1:0] LINE_POSTCODE = 2'd2;
   localparam logic [1:0] LINE_AFTER    = 2'd3;

   typedef enum logic [1:0] {
      NUM_SKIP   = 2'd0,
      NUM_SIGN   = 2'd1,
      NUM_DIGITS = 2'd2,
      NUM_DONE   = 2'd3
   } num_phase_type;

   typedef enum logic [1:0] {
      BK_IDLE = 2'd0,
      BK_MUL  = 2'd1,
      BK_DIV  = 2'd2,
      BK_OUT  = 2'd3
   } back_state_type;

   function automatic logic is_digit(input logic [7:0] b);
      return (b >= CH_ZERO) && (b <= CH_NINE);
   endfunction

   function automatic logic is_upper(input logic [7:0] b);
      return (b >= CH_UP_A) && (b <= CH_UP_Z);
   endfunction

   function automatic logic is_alnum(input logic [7:0] b);
      return is_digit(b) || is_upper(b) || ((b >= CH_LO_A) && (b <= CH_LO_Z));
   endfunction

   function automatic logic is_blank(input logic [7:0] b);
      return (b == CH_SPACE) || (b == CH_TAB) || ((b >= CH_VT) && (b <= CH_CR));
   endfunction

   function automatic logic [7:0] lower_byte(input logic [7:0] b);
      return is_upper(b) ? (b | CASE_BIT) : b;
   endfunction

endpackage

FILE: rtl/record_key_hash_core.sv
// Top level of the record key hash block.
// Depends on rkh_pkg, rkh_front, rkh_fifo and rkh_back.
//
// Takes a three-line mailing record one byte per item (surname, address,
// postcode, each ended by a newline) and, on the item marked tlast, emits
// one result: the bucket index (hash * (house+17)) mod bucket_count, the
// parsed house number and a missing-comma flag. Bytes are taken one per
// cycle while the queue has room; the front end hashes and parses each byte
// as it is taken. A record end hands the record to a two-deep queue, and the
// back end then loads it, does the scaling multiply on one shared 32x32
// multiplier, runs the bit-serial modulo and loads the output register; it
// takes the next record only once that result is loaded. Input stalls only
// while both queue slots are full. A bucket_count of zero gives index 0.
// bucket_count may only be written while the block is idle.
module record_key_hash_core #(
   parameter int HASH_WIDTH = rkh_pkg::HASH_WIDTH_DEF   // 32..64
) (
   input  logic        clock,
   input  logic        reset,
   // record bytes
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] char_byte
   input  logic        req_tlast,    // record_end
   // results
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,    // [31:0] bucket_index, [63:32] house_value
   output logic        rsp_tuser,    // comma_missing
   // bucket_count register
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);
   import rkh_pkg::*;

   localparam int JOB_W = HASH_WIDTH + 33;

   logic [31:0]      bucket_ff;
   logic             byte_acc;
   logic             job_push, job_pop, job_empty, job_full;
   logic [JOB_W-1:0] job_in, job_out;
   logic [31:0]      out_index, out_house;

   always_ff @(posedge clock) begin
      if (reset)          bucket_ff <= BUCKET_RESET;
      else if (csr_wr_en) bucket_ff <= csr_wr_data;
   end

   assign req_tready = !job_full;
   assign byte_acc   = req_tvalid && req_tready;

   rkh_front #(.HASH_WIDTH(HASH_WIDTH)) u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (byte_acc),
      .byte_data  (req_tdata),
      .byte_last  (req_tlast),
      .job_push   (job_push),
      .job_data   (job_in)
   );

   rkh_fifo #(.WIDTH(JOB_W)) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_in),
      .pop       (job_pop),
      .pop_data  (job_out),
      .empty     (job_empty),
      .full      (job_full)
   );

   rkh_back #(.HASH_WIDTH(HASH_WIDTH)) u_back (
      .clock             (clock),
      .reset             (reset),
      .bucket_count      (bucket_ff),
      .job_empty         (job_empty),
      .job_data          (job_out),
      .job_pop           (job_pop),
      .out_valid         (rsp_tvalid),
      .out_ready         (rsp_tready),
      .out_index         (out_index),
      .out_house         (out_house),
      .out_comma_missing (rsp_tuser)
   );

   assign rsp_tdata = {out_house, out_index};

endmodule

FILE: rtl/rkh_front.sv
// Front end: takes record bytes, tracks the line, hashes key bytes and parses
// the house number. Depends on rkh_pkg; pushes finished records to rkh_fifo.
module rkh_front #(
   parameter int HASH_WIDTH = rkh_pkg::HASH_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       byte_valid,
   input  logic [7:0]                 byte_data,
   input  logic                       byte_last,
   output logic                       job_push,
   output logic [HASH_WIDTH+32:0]     job_data    // {comma_missing, house, hash}
);
   import rkh_pkg::*;

   logic [1:0]            line_ff, line_in;
   logic [HASH_WIDTH-1:0] hash_ff, hash_in;
   logic                  closed_ff, closed_in;
   logic [31:0]           num_ff, num_in;
   num_phase_type         phase_ff, phase_in;
   logic                  neg_ff, neg_in;

   logic [HASH_WIDTH-1:0] hash_step;
   logic [7:0]            low_b;
   logic [31:0]           house;

   assign low_b     = lower_byte(byte_data);
   // hash*17 + byte as shift-add
   assign hash_step = hash_ff + (hash_ff << 4) + HASH_WIDTH'(low_b);

   always_comb begin
      line_in   = line_ff;
      hash_in   = hash_ff;
      closed_in = closed_ff;
      num_in    = num_ff;
      phase_in  = phase_ff;
      neg_in    = neg_ff;
      if (byte_data == CH_NEWLINE) begin
         if (line_ff != LINE_AFTER) line_in = line_ff + 2'd1;
      end else begin
         case (line_ff)
            LINE_SURNAME: begin
               if (!closed_ff) begin
                  if (byte_data == CH_COMMA) closed_in = 1'b1;
                  else                       hash_in   = hash_step;
               end
            end
            LINE_ADDRESS: begin
               if ((phase_ff == NUM_SKIP) && is_blank(byte_data)) begin
                  phase_in = NUM_SKIP;
               end else if ((phase_ff == NUM_SKIP) &&
                            ((byte_data == CH_PLUS) || (byte_data == CH_MINUS))) begin
                  neg_in   = (byte_data == CH_MINUS);
                  phase_in = NUM_SIGN;
               end else if ((phase_ff != NUM_DONE) && is_digit(byte_data)) begin
                  num_in   = (num_ff << 3) + (num_ff << 1) + 32'(byte_data - CH_ZERO);
                  phase_in = NUM_DIGITS;
               end else begin
                  phase_in = NUM_DONE;
               end
            end
            LINE_POSTCODE: begin
               if (is_alnum(byte_data)) hash_in = hash_step;
            end
            default: ;
         endcase
      end
   end

   assign house    = neg_in ? (32'd0 - num_in) : num_in;
   assign job_push = byte_valid && byte_last;
   assign job_data = {!closed_in, house, hash_in};

   always_ff @(posedge clock) begin
      if (reset || job_push) begin
         line_ff   <= LINE_SURNAME;
         hash_ff   <= '0;
         closed_ff <= 1'b0;
         num_ff    <= '0;
         phase_ff  <= NUM_SKIP;
         neg_ff    <= 1'b0;
      end else if (byte_valid) begin
         line_ff   <= line_in;
         hash_ff   <= hash_in;
         closed_ff <= closed_in;
         num_ff    <= num_in;
         phase_ff  <= phase_in;
         neg_ff    <= neg_in;
      end
   end

endmodule

FILE: rtl/rkh_fifo.sv
// Short record queue between front and back end.
// Depends on rkh_pkg for its depth.
module rkh_fifo #(
   parameter int WIDTH = rkh_pkg::HASH_WIDTH_DEF + 33
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty,
   output logic             full
);
   import rkh_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign pop_data = slot_ff[rd_ptr_ff];

   function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= bump(wr_ptr_ff);
         if (pop)  rd_ptr_ff <= bump(rd_ptr_ff);
         if (push && !pop)      count_ff <= count_ff + CNT_W'(1);
         else if (pop && !push) count_ff <= count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_data;
   end

endmodule

FILE: rtl/rkh_back.sv
// Back end: scales the record hash by (house+17) with a shared 32x32
// multiplier, reduces it bit-serially by bucket_count, and holds the result.
// Depends on rkh_pkg; fed by rkh_fifo.
module rkh_back #(
   parameter int HASH_WIDTH = rkh_pkg::HASH_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [31:0]            bucket_count,
   input  logic                   job_empty,
   input  logic [HASH_WIDTH+32:0] job_data,
   output logic                   job_pop,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [31:0]            out_index,
   output logic [31:0]            out_house,
   output logic                   out_comma_missing
);
   import rkh_pkg::*;

   localparam int CNT_W = $clog2(HASH_WIDTH);

   back_state_type  state_ff, state_in;
   logic [63:0]     hash_ff;
   logic [31:0]     fact_ff;
   logic [31:0]     house_ff;
   logic            comma_ff;
   logic [63:0]     prod_ff, prod_in;
   logic [1:0]      step_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [31:0]     rem_ff, rem_in;
   logic            valid_ff;
   logic [31:0]     index_ff, hold_house_ff;
   logic            hold_comma_ff;

   logic            out_free, load_out;
   logic [31:0]     mul_a, mul_b, fact_hi;
   logic [63:0]     mul_p;
   logic [32:0]     rem_sh;

   assign out_free = !valid_ff || out_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: if (!job_empty)              state_in = BK_MUL;
         BK_MUL:  if (step_ff == 2'd2)         state_in = BK_DIV;
         BK_DIV:  if (cnt_ff == '0)            state_in = BK_OUT;
         BK_OUT:  if (out_free)                state_in = BK_IDLE;
         default:                              state_in = BK_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      job_pop  = 1'b0;
      load_out = 1'b0;
      unique case (state_ff)
         BK_IDLE: job_pop  = !job_empty;
         BK_OUT:  load_out = out_free;
         default: ;
      endcase
   end

   // 64-bit product mod 2^64 from three 32x32 partial products
   assign fact_hi = {32{fact_ff[31]}};
   assign mul_a   = (step_ff == 2'd1) ? hash_ff[63:32] : hash_ff[31:0];
   assign mul_b   = (step_ff == 2'd2) ? fact_hi : fact_ff;
   assign mul_p   = {32'd0, mul_a} * {32'd0, mul_b};
   assign prod_in = (step_ff == 2'd0) ? mul_p : prod_ff + {mul_p[31:0], 32'd0};

   // restoring reduction, one dividend bit a cycle
   assign rem_sh = {rem_ff, prod_ff[HASH_WIDTH-1]};
   assign rem_in = (rem_sh >= {1'b0, bucket_count}) ? 32'(rem_sh - {1'b0, bucket_count})
                                                      : rem_sh[31:0];

   always_ff @(posedge clock) begin
      if (reset) state_ff <= BK_IDLE;
      else       state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      if (job_pop) begin
         hash_ff  <= 64'(job_data[HASH_WIDTH-1:0]);
         fact_ff  <= job_data[HASH_WIDTH+31:HASH_WIDTH] + HOUSE_BIAS;
         house_ff <= job_data[HASH_WIDTH+31:HASH_WIDTH];
         comma_ff <= job_data[HASH_WIDTH+32];
         step_ff  <= 2'd0;
         cnt_ff   <= CNT_W'(HASH_WIDTH - 1);
         rem_ff   <= '0;
      end else if (state_ff == BK_MUL) begin
         prod_ff <= prod_in;
         step_ff <= step_ff + 2'd1;
      end else if (state_ff == BK_DIV) begin
         rem_ff  <= rem_in;
         prod_ff <= prod_ff << 1;
         cnt_ff  <= cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset)         valid_ff <= 1'b0;
      else if (load_out) valid_ff <= 1'b1;
      else if (out_ready) valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         index_ff      <= (bucket_count == '0) ? '0 : rem_ff;
         hold_house_ff <= house_ff;
         hold_comma_ff <= comma_ff;
      end
   end

   assign out_valid         = valid_ff;
   assign out_index         = index_ff;
   assign out_house         = hold_house_ff;
   assign out_comma_missing = hold_comma_ff;

endmodule

FILE: rtl/rkh_checker.sv
// Port-level checks for record_key_hash_core, bound to the top level.
// No package dependencies.
module rkh_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic        rsp_tuser
);

   // out of reset: no result held, queue open
   a_reset_clean: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && req_tready))
      else $error("result or stall present after reset");

   // a held result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("result changed while stalled");

   // the queue only fills on a record end
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      $fell(req_tready) |-> $past(req_tvalid && req_tlast))
      else $error("input stalled without a queued record");

endmodule

bind record_key_hash_core rkh_checker u_rkh_checker (.*);
